@@ rtl/planar_two_link_arm_ik_step_assert.svh @@
// Assertion macros shared by the arm kinematics RTL.
`ifndef PLANAR_TWO_LINK_ARM_IK_STEP_ASSERT_SVH
`define PLANAR_TWO_LINK_ARM_IK_STEP_ASSERT_SVH

// Clocked check, muted while reset is high.
`define TLAIK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define TLAIK_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/tlaik_pkg.sv @@
// Types, constants and CORDIC helpers for the two-link arm kinematics block.
`timescale 1ns / 1ps
package tlaik_pkg;

   localparam int COS_W  = 19;
   localparam int J_W    = 28;
   localparam int NUM_W  = 54;
   localparam int DET_W  = 34;
   localparam int TIP_W  = 18;
   localparam int STEP_W = 32;
   localparam int ATAN_COUNT = 24;

   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
   localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

   // arctan(2^-i) in 2^-32 turn
   localparam logic [31:0] ATAN_TURNS [0:ATAN_COUNT-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   localparam logic [1:0] CSR_INNER_LEN = 2'd0;
   localparam logic [1:0] CSR_OUTER_LEN = 2'd1;
   localparam logic [1:0] CSR_DET_THR   = 2'd2;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
      logic               flip;
   } cordic_lane_type;

   typedef struct packed {
      logic              vld;
      cordic_lane_type   sh;
      cordic_lane_type   el;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
   } cordic_stage_type;

   typedef struct packed {
      logic                     vld;
      logic                     sing;
      logic                     ovf_s;
      logic                     ovf_e;
      logic                     neg_s;
      logic                     neg_e;
      logic [NUM_W-1:0]         rem_s;
      logic [NUM_W-1:0]         rem_e;
      logic [STEP_W-1:0]        q_s;
      logic [STEP_W-1:0]        q_e;
      logic [DET_W-1:0]         ud;
      logic signed [TIP_W-1:0]  tip_x;
      logic signed [TIP_W-1:0]  tip_y;
      logic signed [DET_W-1:0]  det;
   } div_stage_type;

   // Place the angle in a 32-bit turn, fold into the right half plane.
   function automatic cordic_lane_type cordic_seed(logic [15:0] angle, logic [31:0] mask);
      logic [31:0]        turn;
      logic signed [32:0] z;
      cordic_lane_type    r;
      turn   = {angle, 16'h0000} & mask;
      z      = signed'({turn[31], turn});
      r.x    = CORDIC_GAIN;
      r.y    = '0;
      r.flip = 1'b0;
      r.z    = z;
      if (z > QUARTER_TURN) begin
         r.z    = z - HALF_TURN;
         r.flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
         r.z    = z + HALF_TURN;
         r.flip = 1'b1;
      end
      return r;
   endfunction

   function automatic cordic_lane_type cordic_rotate(cordic_lane_type lane, logic [4:0] idx);
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [32:0] at;
      cordic_lane_type    r;
      r  = lane;
      xs = lane.x >>> idx;
      ys = lane.y >>> idx;
      at = signed'({1'b0, ATAN_TURNS[idx]});
      if (!lane.z[32]) begin
         r.x = lane.x - ys;
         r.y = lane.y + xs;
         r.z = lane.z - at;
      end else begin
         r.x = lane.x + ys;
         r.y = lane.y - xs;
         r.z = lane.z + at;
      end
      return r;
   endfunction

endpackage

@@ rtl/planar_two_link_arm_ik_step.sv @@
// Two-link planar arm: forward kinematics, Jacobian determinant and inverse step.
//
//  channel | dir | protocol     | content
//  req_    | in  | stream       | tdata: shoulder, elbow, dx, dy (16b each)
//  rsp_    | out | stream       | tdata: tip_x, tip_y, det, steps; tuser: singular
//  csr_    | in  | APB register | link lengths, determinant threshold
//
// One item per cycle unless the output stalls; a result passes the CORDIC stages,
// stages A to H, the 32 bit-per-stage restoring divider for the two steps, and the
// output register.
// Reset is synchronous; it clears all valid bits and presets the configuration registers.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "planar_two_link_arm_ik_step_assert.svh"
module planar_two_link_arm_ik_step #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // shoulder_angle, elbow_angle, target_dx, target_dy
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // tip_x, tip_y, jacobian_det, shoulder_step, elbow_step
   output logic [0:0]    rsp_tuser,   // singular
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
   localparam int COS_W  = tlaik_pkg::COS_W;
   localparam int J_W    = tlaik_pkg::J_W;
   localparam int NUM_W  = tlaik_pkg::NUM_W;
   localparam int DET_W  = tlaik_pkg::DET_W;
   localparam int TIP_W  = tlaik_pkg::TIP_W;
   localparam int STEP_W = tlaik_pkg::STEP_W;

   // ---------------- configuration registers ----------------
   logic [15:0] inner_len_ff, outer_len_ff, det_thr_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_len_ff <= 16'd256;
         outer_len_ff <= 16'd256;
         det_thr_ff   <= 16'd1;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            tlaik_pkg::CSR_INNER_LEN: inner_len_ff <= csr_pwdata[15:0];
            tlaik_pkg::CSR_OUTER_LEN: outer_len_ff <= csr_pwdata[15:0];
            tlaik_pkg::CSR_DET_THR:   det_thr_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         tlaik_pkg::CSR_INNER_LEN: csr_prdata = {16'h0000, inner_len_ff};
         tlaik_pkg::CSR_OUTER_LEN: csr_prdata = {16'h0000, outer_len_ff};
         tlaik_pkg::CSR_DET_THR:   csr_prdata = {16'h0000, det_thr_ff};
         default:                  csr_prdata = 32'h0000_0000;
      endcase
   end

   // ---------------- pipeline advance ----------------
   logic rsp_valid_ff;
   logic ce;

   assign ce         = !rsp_valid_ff || rsp_tready;
   assign req_tready = ce;

   // ---------------- CORDIC stages ----------------
   tlaik_pkg::cordic_stage_type cord_in [0:CORDIC_STAGES];
   tlaik_pkg::cordic_stage_type cord_ff [0:CORDIC_STAGES];

   always_comb begin
      cord_in[0].vld = req_tvalid;
      cord_in[0].sh  = tlaik_pkg::cordic_seed(req_tdata[15:0], ANGLE_MASK);
      cord_in[0].el  = tlaik_pkg::cordic_seed(req_tdata[31:16], ANGLE_MASK);
      cord_in[0].dx  = signed'(req_tdata[47:32]);
      cord_in[0].dy  = signed'(req_tdata[63:48]);
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      always_comb begin
         cord_in[g+1]    = cord_ff[g];
         cord_in[g+1].sh = tlaik_pkg::cordic_rotate(cord_ff[g].sh, 5'(g));
         cord_in[g+1].el = tlaik_pkg::cordic_rotate(cord_ff[g].el, 5'(g));
      end
   end

   for (genvar g = 0; g <= CORDIC_STAGES; g++) begin : g_cordic_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            cord_ff[g].vld <= 1'b0;
         end else if (ce) begin
            cord_ff[g] <= cord_in[g];
         end
      end
   end

   // ---------------- stage A: sine and cosine in Q2.16 ----------------
   logic                    a_vld_ff;
   logic signed [COS_W-1:0] a_cs_ff, a_ss_ff, a_ce_ff, a_se_ff;
   logic signed [COS_W-1:0] a_cs_in, a_ss_in, a_ce_in, a_se_in;
   logic signed [15:0]      a_dx_ff, a_dy_ff;

   function automatic logic signed [COS_W-1:0] to_q16(logic signed [33:0] v, logic flip);
      logic signed [33:0] f;
      logic signed [33:0] r;
      f = flip ? -v : v;
      r = (f + 34'sd8192) >>> 14;
      return r[COS_W-1:0];
   endfunction

   always_comb begin
      a_cs_in = to_q16(cord_ff[CORDIC_STAGES].sh.x, cord_ff[CORDIC_STAGES].sh.flip);
      a_ss_in = to_q16(cord_ff[CORDIC_STAGES].sh.y, cord_ff[CORDIC_STAGES].sh.flip);
      a_ce_in = to_q16(cord_ff[CORDIC_STAGES].el.x, cord_ff[CORDIC_STAGES].el.flip);
      a_se_in = to_q16(cord_ff[CORDIC_STAGES].el.y, cord_ff[CORDIC_STAGES].el.flip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (ce) begin
         a_vld_ff <= cord_ff[CORDIC_STAGES].vld;
         a_cs_ff  <= a_cs_in;
         a_ss_ff  <= a_ss_in;
         a_ce_ff  <= a_ce_in;
         a_se_ff  <= a_se_in;
         a_dx_ff  <= cord_ff[CORDIC_STAGES].dx;
         a_dy_ff  <= cord_ff[CORDIC_STAGES].dy;
      end
   end

   // ---------------- stage B: angle-sum products ----------------
   logic                    b_vld_ff;
   logic signed [37:0]      b_pcc_ff, b_pss_ff, b_pcs_ff, b_psc_ff;
   logic signed [COS_W-1:0] b_cs_ff, b_ss_ff;
   logic signed [15:0]      b_dx_ff, b_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (ce) begin
         b_vld_ff <= a_vld_ff;
         b_pcc_ff <= a_ce_ff * a_cs_ff;
         b_pss_ff <= a_se_ff * a_ss_ff;
         b_pcs_ff <= a_ce_ff * a_ss_ff;
         b_psc_ff <= a_se_ff * a_cs_ff;
         b_cs_ff  <= a_cs_ff;
         b_ss_ff  <= a_ss_ff;
         b_dx_ff  <= a_dx_ff;
         b_dy_ff  <= a_dy_ff;
      end
   end

   // ---------------- stage C: cos/sin of the sum, inner link terms ----------------
   logic               c_vld_ff;
   logic signed [37:0] c_sumc_ff, c_sums_ff;
   logic signed [35:0] c_lsc_ff, c_lss_ff;
   logic signed [15:0] c_dx_ff, c_dy_ff;
   logic signed [16:0] ls_s, le_s;

   assign ls_s = signed'({1'b0, inner_len_ff});
   assign le_s = signed'({1'b0, outer_len_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (ce) begin
         c_vld_ff  <= b_vld_ff;
         c_sumc_ff <= b_pcc_ff - b_pss_ff;
         c_sums_ff <= b_pcs_ff + b_psc_ff;
         c_lsc_ff  <= ls_s * b_cs_ff;
         c_lss_ff  <= ls_s * b_ss_ff;
         c_dx_ff   <= b_dx_ff;
         c_dy_ff   <= b_dy_ff;
      end
   end

   // ---------------- stage D: outer link terms ----------------
   logic               d_vld_ff;
   logic signed [53:0] d_lecs_ff, d_less_ff;
   logic signed [35:0] d_lsc_ff, d_lss_ff;
   logic signed [15:0] d_dx_ff, d_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (ce) begin
         d_vld_ff  <= c_vld_ff;
         d_lecs_ff <= 54'(le_s * c_sumc_ff);
         d_less_ff <= 54'(le_s * c_sums_ff);
         d_lsc_ff  <= c_lsc_ff;
         d_lss_ff  <= c_lss_ff;
         d_dx_ff   <= c_dx_ff;
         d_dy_ff   <= c_dy_ff;
      end
   end

   // ---------------- stage E: tip position in Q.32 ----------------
   logic               e_vld_ff;
   logic signed [53:0] e_x_ff, e_y_ff, e_lecs_ff, e_less_ff;
   logic signed [15:0] e_dx_ff, e_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (ce) begin
         e_vld_ff  <= d_vld_ff;
         e_x_ff    <= d_lecs_ff + (54'(d_lsc_ff) <<< 16);
         e_y_ff    <= d_less_ff + (54'(d_lss_ff) <<< 16);
         e_lecs_ff <= d_lecs_ff;
         e_less_ff <= d_less_ff;
         e_dx_ff   <= d_dx_ff;
         e_dy_ff   <= d_dy_ff;
      end
   end

   // ---------------- stage F: Jacobian entries, tip rounding and saturation ----------------
   logic                    f_vld_ff;
   logic signed [J_W-1:0]   f_ja_ff, f_jb_ff, f_jc_ff, f_jd_ff;
   logic signed [J_W-1:0]   f_ja_in, f_jb_in, f_jc_in, f_jd_in;
   logic signed [TIP_W-1:0] f_tx_ff, f_ty_ff, f_tx_in, f_ty_in;
   logic signed [15:0]      f_dx_ff, f_dy_ff;

   function automatic logic signed [J_W-1:0] rnd24(logic signed [53:0] v);
      logic signed [53:0] r;
      r = (v + 54'sd8388608) >>> 24;
      return r[J_W-1:0];
   endfunction

   function automatic logic signed [TIP_W-1:0] tip_sat(logic signed [53:0] v);
      logic signed [53:0] r;
      r = (v + 54'sd2147483648) >>> 32;
      if (r > 54'sd131071) begin
         return 18'sd131071;
      end else if (r < -54'sd131072) begin
         return -18'sd131072;
      end
      return r[TIP_W-1:0];
   endfunction

   always_comb begin
      f_ja_in = -rnd24(e_y_ff);
      f_jb_in = -rnd24(e_less_ff);
      f_jc_in = rnd24(e_x_ff);
      f_jd_in = rnd24(e_lecs_ff);
      f_tx_in = tip_sat(e_x_ff);
      f_ty_in = tip_sat(e_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (ce) begin
         f_vld_ff <= e_vld_ff;
         f_ja_ff  <= f_ja_in;
         f_jb_ff  <= f_jb_in;
         f_jc_ff  <= f_jc_in;
         f_jd_ff  <= f_jd_in;
         f_tx_ff  <= f_tx_in;
         f_ty_ff  <= f_ty_in;
         f_dx_ff  <= e_dx_ff;
         f_dy_ff  <= e_dy_ff;
      end
   end

   // ---------------- stage G: determinant and adjugate products ----------------
   logic                    g_vld_ff;
   logic signed [55:0]      g_pad_ff, g_pbc_ff;
   logic signed [43:0]      g_pdx_ff, g_pbdy_ff, g_pady_ff, g_pcdx_ff;
   logic signed [TIP_W-1:0] g_tx_ff, g_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (ce) begin
         g_vld_ff  <= f_vld_ff;
         g_pad_ff  <= f_ja_ff * f_jd_ff;
         g_pbc_ff  <= f_jb_ff * f_jc_ff;
         g_pdx_ff  <= f_jd_ff * f_dx_ff;
         g_pbdy_ff <= f_jb_ff * f_dy_ff;
         g_pady_ff <= f_ja_ff * f_dy_ff;
         g_pcdx_ff <= f_jc_ff * f_dx_ff;
         g_tx_ff   <= f_tx_ff;
         g_ty_ff   <= f_ty_ff;
      end
   end

   // ---------------- stage H: determinant, step numerators ----------------
   logic                    h_vld_ff;
   logic signed [DET_W-1:0] h_det_ff, h_det_in;
   logic signed [NUM_W-1:0] h_ns_ff, h_ne_ff;
   logic signed [TIP_W-1:0] h_tx_ff, h_ty_ff;
   logic signed [57:0]      h_diff;
   logic signed [57:0]      h_rnd;

   always_comb begin
      h_diff = 58'(g_pad_ff) - 58'(g_pbc_ff);
      h_rnd  = (h_diff + 58'sd32768) >>> 16;
      if (h_rnd > 58'sd8589934591) begin
         h_det_in = 34'sh1_FFFF_FFFF;
      end else if (h_rnd < -58'sd8589934592) begin
         h_det_in = 34'sh2_0000_0000;
      end else begin
         h_det_in = h_rnd[DET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (ce) begin
         h_vld_ff <= g_vld_ff;
         h_det_ff <= h_det_in;
         h_ns_ff  <= (NUM_W'(g_pdx_ff) - NUM_W'(g_pbdy_ff)) <<< 8;
         h_ne_ff  <= (NUM_W'(g_pady_ff) - NUM_W'(g_pcdx_ff)) <<< 8;
         h_tx_ff  <= g_tx_ff;
         h_ty_ff  <= g_ty_ff;
      end
   end

   // ---------------- stage I and divider ----------------
   tlaik_pkg::div_stage_type div_in [0:STEP_W];
   tlaik_pkg::div_stage_type div_ff [0:STEP_W];
   logic [DET_W-1:0] i_mag;
   logic [NUM_W-1:0] i_un_s, i_un_e;

   always_comb begin
      i_mag  = h_det_ff[DET_W-1] ? DET_W'(-h_det_ff) : DET_W'(h_det_ff);
      i_un_s = h_ns_ff[NUM_W-1] ? NUM_W'(-h_ns_ff) : NUM_W'(h_ns_ff);
      i_un_e = h_ne_ff[NUM_W-1] ? NUM_W'(-h_ne_ff) : NUM_W'(h_ne_ff);
      div_in[0].vld   = h_vld_ff;
      div_in[0].sing  = !(i_mag > DET_W'(det_thr_ff));
      div_in[0].ud    = i_mag;
      div_in[0].rem_s = i_un_s;
      div_in[0].rem_e = i_un_e;
      div_in[0].q_s   = '0;
      div_in[0].q_e   = '0;
      // quotient of 2^32 or more saturates regardless of sign
      div_in[0].ovf_s = (i_un_s >> STEP_W) >= NUM_W'(i_mag);
      div_in[0].ovf_e = (i_un_e >> STEP_W) >= NUM_W'(i_mag);
      div_in[0].neg_s = h_ns_ff[NUM_W-1] ^ h_det_ff[DET_W-1];
      div_in[0].neg_e = h_ne_ff[NUM_W-1] ^ h_det_ff[DET_W-1];
      div_in[0].tip_x = h_tx_ff;
      div_in[0].tip_y = h_ty_ff;
      div_in[0].det   = h_det_ff;
   end

   for (genvar g = 0; g < STEP_W; g++) begin : g_div
      localparam int BIT = STEP_W - 1 - g;
      always_comb begin
         div_in[g+1] = div_ff[g];
         if ((div_ff[g].rem_s >> BIT) >= NUM_W'(div_ff[g].ud)) begin
            div_in[g+1].rem_s    = div_ff[g].rem_s - (NUM_W'(div_ff[g].ud) << BIT);
            div_in[g+1].q_s[BIT] = 1'b1;
         end
         if ((div_ff[g].rem_e >> BIT) >= NUM_W'(div_ff[g].ud)) begin
            div_in[g+1].rem_e    = div_ff[g].rem_e - (NUM_W'(div_ff[g].ud) << BIT);
            div_in[g+1].q_e[BIT] = 1'b1;
         end
      end
   end

   for (genvar g = 0; g <= STEP_W; g++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[g].vld <= 1'b0;
         end else if (ce) begin
            div_ff[g] <= div_in[g];
         end
      end
   end

   // ---------------- output register ----------------
   logic signed [TIP_W-1:0]  out_tx_ff, out_ty_ff;
   logic signed [DET_W-1:0]  out_det_ff;
   logic [STEP_W-1:0]        out_ss_ff, out_es_ff, out_ss_in, out_es_in;
   logic                     out_sing_ff;

   function automatic logic [STEP_W-1:0] step_sat(logic sing, logic ovf, logic neg,
                                                   logic [STEP_W-1:0] q);
      if (sing) begin
         return '0;
      end else if (ovf || q[STEP_W-1]) begin
         return neg ? {1'b1, {(STEP_W-1){1'b0}}} : {1'b0, {(STEP_W-1){1'b1}}};
      end
      return neg ? -q : q;
   endfunction

   always_comb begin
      out_ss_in = step_sat(div_ff[STEP_W].sing, div_ff[STEP_W].ovf_s,
                           div_ff[STEP_W].neg_s, div_ff[STEP_W].q_s);
      out_es_in = step_sat(div_ff[STEP_W].sing, div_ff[STEP_W].ovf_e,
                           div_ff[STEP_W].neg_e, div_ff[STEP_W].q_e);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= div_ff[STEP_W].vld;
         out_tx_ff    <= div_ff[STEP_W].tip_x;
         out_ty_ff    <= div_ff[STEP_W].tip_y;
         out_det_ff   <= div_ff[STEP_W].det;
         out_ss_ff    <= out_ss_in;
         out_es_ff    <= out_es_in;
         out_sing_ff  <= div_ff[STEP_W].sing;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {2'b00, out_es_ff, out_ss_ff, out_det_ff, out_ty_ff, out_tx_ff};
   assign rsp_tuser[0] = out_sing_ff;

   // ---------------- assertions ----------------
   `TLAIK_ASSERT(a_sing_zero_steps,
      rsp_valid_ff && out_sing_ff |-> (out_ss_ff == '0) && (out_es_ff == '0),
      "singular result carries a nonzero step")
   `TLAIK_ASSERT(a_nonsing_det,
      rsp_valid_ff && !out_sing_ff |-> out_det_ff != '0,
      "step taken with a zero determinant")
   `TLAIK_ASSERT(a_empty_out_ready,
      !rsp_valid_ff |-> req_tready,
      "input held off with an empty output register")
   `TLAIK_ASSERT(a_div_rem,
      div_ff[STEP_W].vld && !div_ff[STEP_W].sing && !div_ff[STEP_W].ovf_s
         |-> div_ff[STEP_W].rem_s < NUM_W'(div_ff[STEP_W].ud),
      "divider remainder not below divisor")
   `TLAIK_ASSERT_RST(a_reset_empty,
      reset |=> !rsp_valid_ff,
      "output valid right after reset")

endmodule
